>>> src/fnfa_pkg.sv
// Package for the first/next-fit block allocator: field widths, codes and ALU types.
// Shared by the interfaces and the modules of the block apart from fnfa_ram; depends on nothing.
`default_nettype none

package fnfa_pkg;

	// Default number of blocks handed to the top level.
	localparam int NUM_BLOCKS_DEF = 32;

	// Fixed field widths of the channels.
	localparam int KIND_W     = 2;
	localparam int REQ_W      = 15;
	localparam int BIDX_W     = 5;
	localparam int FREE_W     = 10;
	localparam int STAT_W     = 2;
	localparam int HOLES_W    = 6;
	localparam int USED_W     = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	// Saturation limits of the result fields.
	localparam int HOLES_MAX = 63;
	localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

	typedef logic [KIND_W-1:0]    kind_t;
	typedef logic [STAT_W-1:0]    status_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [FREE_W-1:0]    free_t;

	// Item kinds.
	localparam kind_t KIND_ALLOC   = 2'd0;
	localparam kind_t KIND_RELEASE = 2'd1;
	localparam kind_t KIND_LOAD    = 2'd2;

	// Result status codes.
	localparam status_t STAT_ALLOC    = 2'd0;
	localparam status_t STAT_NOFIT    = 2'd1;
	localparam status_t STAT_RELEASED = 2'd2;
	localparam status_t STAT_LOADED   = 2'd3;

	// Configuration register indexes and reset values.
	localparam cfg_idx_t REG_BLOCK_CAPACITY = 2'd0;
	localparam cfg_idx_t REG_FIT_POLICY     = 2'd1;
	localparam free_t    CAP_RESET          = 10'd16;

	// Operands of the shared compare/subtract unit.
	localparam int OPW = REQ_W;
	typedef logic [OPW-1:0] opnd_t;

	typedef struct packed {
		opnd_t             a;
		opnd_t             b;
		logic [USED_W-1:0] acc;
	} alu_req_t;

	typedef struct packed {
		logic              lt;
		opnd_t             diff;
		logic [USED_W-1:0] acc;
	} alu_rsp_t;

endpackage

`default_nettype wire

>>> src/fnfa_in_if.sv
// Input item channel of the block allocator: valid, ready and the item fields.
// Depends on fnfa_pkg for the field types.
`default_nettype none

interface fnfa_in_if;
	import fnfa_pkg::*;

	logic              valid;
	logic              ready;
	kind_t             kind;
	logic [REQ_W-1:0]  request_size;
	logic [BIDX_W-1:0] block_index;
	free_t             load_free;

	modport source (output valid, kind, request_size, block_index, load_free, input ready);
	modport sink (input valid, kind, request_size, block_index, load_free, output ready);
endinterface

`default_nettype wire

>>> src/fnfa_out_if.sv
// Result channel of the block allocator: valid, ready and the result fields.
// Depends on fnfa_pkg for the field types.
`default_nettype none

interface fnfa_out_if;
	import fnfa_pkg::*;

	logic               valid;
	logic               ready;
	status_t            status;
	logic [BIDX_W-1:0]  start_block;
	logic [HOLES_W-1:0] holes_seen;
	logic [USED_W-1:0]  used_total;

	modport source (output valid, status, start_block, holes_seen, used_total, input ready);
	modport sink (input valid, status, start_block, holes_seen, used_total, output ready);
endinterface

`default_nettype wire

>>> src/fnfa_cfg_if.sv
// Configuration write channel of the block allocator: valid, ready, index and data.
// Depends on fnfa_pkg for the field types.
`default_nettype none

interface fnfa_cfg_if;
	import fnfa_pkg::*;

	logic                  valid;
	logic                  ready;
	cfg_idx_t              index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/fnfa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the free amount of every block.
`default_nettype none

module fnfa_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

`default_nettype wire

>>> src/fnfa_alu.sv
// Shared compare/subtract unit of the block allocator, with a saturating accumulate.
// Depends on fnfa_pkg for the request and response structs.
`default_nettype none

module fnfa_alu (
	input  fnfa_pkg::alu_req_t req,
	output fnfa_pkg::alu_rsp_t rsp
);
	import fnfa_pkg::*;

	logic            lt;
	opnd_t           diff;
	logic [USED_W:0] acc_sum;

	// Compare, then subtract the smaller operand from the larger one.
	always_comb begin
		lt   = req.a < req.b;
		diff = lt ? (req.b - req.a) : (req.a - req.b);
	end

	// Add a - b to the accumulator when a is not below b, saturating at the field limit.
	always_comb begin
		acc_sum = {1'b0, req.acc} + (lt ? '0 : {1'b0, diff});
		rsp.lt   = lt;
		rsp.diff = diff;
		rsp.acc  = acc_sum[USED_W] ? USED_MAX : acc_sum[USED_W-1:0];
	end
endmodule

`default_nettype wire

>>> src/fnfa_seq.sv
// Sequencer of the block allocator: clearing, scan, backward run, fill, release/load write and usage sum over the RAM.
// Depends on fnfa_pkg, the item and result channel interfaces, and drives fnfa_ram and fnfa_alu.
`default_nettype none

module fnfa_seq #(
	parameter int NUM_BLOCKS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fnfa_pkg::free_t               cap,
	input  logic                          policy,
	fnfa_in_if.sink                       item,
	fnfa_out_if.source                    result,
	output logic                          ram_we,
	output logic [$clog2(NUM_BLOCKS)-1:0] ram_waddr,
	output fnfa_pkg::free_t               ram_wdata,
	output logic [$clog2(NUM_BLOCKS)-1:0] ram_raddr,
	input  fnfa_pkg::free_t               ram_rdata,
	output fnfa_pkg::alu_req_t            alu_req,
	input  fnfa_pkg::alu_rsp_t            alu_rsp
);
	import fnfa_pkg::*;

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_EX,
		ST_RUN_RD,
		ST_RUN_EX,
		ST_FILL_RD,
		ST_FILL_EX,
		ST_WRITE,
		ST_SUM,
		ST_SUM_LAST,
		ST_FINISH
	} state_t;

	state_t             state_q;
	kind_t              kind_q;
	opnd_t              req_q;
	free_t              ld_q;
	logic [IDX_W-1:0]   bidx_q;
	logic               idx_ok_q;
	logic [IDX_W-1:0]   pos_q;
	logic [IDX_W-1:0]   n_q;
	logic [IDX_W-1:0]   j_q;
	logic [IDX_W-1:0]   k_q;
	logic [IDX_W-1:0]   addr_q;
	logic [IDX_W-1:0]   next_start_q;
	logic [IDX_W-1:0]   start_q;
	opnd_t              need_q;
	logic [CNT_W-1:0]   holes_q;
	status_t            status_q;
	logic [USED_W-1:0]  acc_q;
	logic               out_vld_q;
	status_t            out_status_q;
	logic [BIDX_W-1:0]  out_start_q;
	logic [HOLES_W-1:0] out_holes_q;
	logic [USED_W-1:0]  out_used_q;

	logic             d_zero;
	logic             blk_fail;
	logic             last_blk;
	logic [IDX_W-1:0] pos_inc;

	assign d_zero   = (ram_rdata == '0);
	assign last_blk = (n_q == LAST_IDX);
	assign pos_inc  = (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;

	// The scanned block gives up when it is full, or when neither it nor a run ending there fits.
	always_comb begin
		unique case (state_q)
			ST_SCAN_EX: blk_fail = d_zero || (alu_rsp.lt && pos_q == '0);
			ST_RUN_EX:  blk_fail = d_zero || (alu_rsp.lt && j_q == IDX_W'(1));
			default:    blk_fail = 1'b0;
		endcase
	end

	// RAM read address for each read state.
	always_comb begin
		unique case (state_q)
			ST_RUN_RD:  ram_raddr = j_q - 1'b1;
			ST_FILL_RD: ram_raddr = k_q;
			ST_SUM:     ram_raddr = addr_q;
			default:    ram_raddr = pos_q;
		endcase
	end

	// Operands of the shared unit.
	always_comb begin
		alu_req.a   = OPW'(ram_rdata);
		alu_req.b   = need_q;
		alu_req.acc = '0;
		unique case (state_q)
			ST_SCAN_EX: alu_req.b = req_q;
			ST_WRITE: begin
				alu_req.a = OPW'(ld_q);
				alu_req.b = OPW'(cap);
			end
			ST_SUM, ST_SUM_LAST: begin
				alu_req.a   = OPW'(cap);
				alu_req.b   = OPW'(ram_rdata);
				alu_req.acc = acc_q;
			end
			default: ;
		endcase
	end

	// RAM writes: clearing pass, hole reduction, run fill, release and load.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = FREE_W'(alu_rsp.diff);
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = addr_q;
				ram_wdata = '0;
			end
			ST_SCAN_EX: ram_we = !d_zero && !alu_rsp.lt;
			ST_FILL_EX: begin
				ram_we    = 1'b1;
				ram_waddr = k_q;
				ram_wdata = alu_rsp.lt ? '0 : FREE_W'(alu_rsp.diff);
			end
			ST_WRITE: begin
				ram_we    = idx_ok_q;
				ram_waddr = bidx_q;
				ram_wdata = (kind_q == KIND_RELEASE || !alu_rsp.lt) ? cap : ld_q;
			end
			default: ;
		endcase
	end

	assign item.ready         = (state_q == ST_IDLE);
	assign result.valid       = out_vld_q;
	assign result.status      = out_status_q;
	assign result.start_block = out_start_q;
	assign result.holes_seen  = out_holes_q;
	assign result.used_total  = out_used_q;

	// Sequencer state and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			kind_q       <= KIND_ALLOC;
			req_q        <= '0;
			ld_q         <= '0;
			bidx_q       <= '0;
			idx_ok_q     <= 1'b0;
			pos_q        <= '0;
			n_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			addr_q       <= '0;
			next_start_q <= '0;
			start_q      <= '0;
			need_q       <= '0;
			holes_q      <= '0;
			status_q     <= STAT_NOFIT;
			acc_q        <= '0;
			out_vld_q    <= 1'b0;
			out_status_q <= STAT_NOFIT;
			out_start_q  <= '0;
			out_holes_q  <= '0;
			out_used_q   <= '0;
		end else begin
			// The finish step decides the result valid on its own.
			if (out_vld_q && result.ready && state_q != ST_FINISH) begin
				out_vld_q <= 1'b0;
			end

			// A block that gives up moves the scan on, or ends it after the last block.
			if (blk_fail) begin
				if (last_blk) begin
					state_q <= ST_SUM;
				end else begin
					n_q     <= n_q + 1'b1;
					pos_q   <= pos_inc;
					state_q <= ST_SCAN_RD;
				end
			end

			unique case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item.valid) begin
						kind_q   <= item.kind;
						req_q    <= item.request_size;
						ld_q     <= item.load_free;
						bidx_q   <= IDX_W'(item.block_index);
						idx_ok_q <= 32'(item.block_index) < 32'(NUM_BLOCKS);
						pos_q    <= policy ? next_start_q : '0;
						n_q      <= '0;
						holes_q  <= '0;
						start_q  <= '0;
						addr_q   <= '0;
						acc_q    <= '0;
						unique case (item.kind)
							KIND_ALLOC: begin
								status_q <= STAT_NOFIT;
								state_q  <= ST_SCAN_RD;
							end
							KIND_RELEASE: begin
								status_q <= STAT_RELEASED;
								state_q  <= ST_WRITE;
							end
							KIND_LOAD: begin
								status_q <= STAT_LOADED;
								state_q  <= ST_WRITE;
							end
							default: begin
								status_q <= STAT_NOFIT;
								state_q  <= ST_SUM;
							end
						endcase
					end
				end
				ST_SCAN_RD: state_q <= ST_SCAN_EX;
				ST_SCAN_EX: begin
					if (!d_zero) begin
						holes_q <= holes_q + 1'b1;
					end
					if (!blk_fail) begin
						if (!alu_rsp.lt) begin
							// The hole alone holds the request.
							start_q  <= pos_q;
							status_q <= STAT_ALLOC;
							if (policy) begin
								next_start_q <= pos_q;
							end
							state_q <= ST_SUM;
						end else begin
							// Start a backward run with what is still missing.
							need_q  <= alu_rsp.diff;
							j_q     <= pos_q;
							state_q <= ST_RUN_RD;
						end
					end
				end
				ST_RUN_RD: state_q <= ST_RUN_EX;
				ST_RUN_EX: begin
					if (!blk_fail) begin
						j_q <= j_q - 1'b1;
						if (!alu_rsp.lt) begin
							// The run holds the request: fill from the scanned block down.
							k_q     <= pos_q;
							need_q  <= req_q;
							state_q <= ST_FILL_RD;
						end else begin
							need_q  <= alu_rsp.diff;
							state_q <= ST_RUN_RD;
						end
					end
				end
				ST_FILL_RD: state_q <= ST_FILL_EX;
				ST_FILL_EX: begin
					if (!alu_rsp.lt || k_q == j_q) begin
						start_q  <= j_q;
						status_q <= STAT_ALLOC;
						if (policy) begin
							next_start_q <= pos_q;
						end
						state_q <= ST_SUM;
					end else begin
						need_q  <= alu_rsp.diff;
						k_q     <= k_q - 1'b1;
						state_q <= ST_FILL_RD;
					end
				end
				ST_WRITE: state_q <= ST_SUM;
				ST_SUM: begin
					// Read data comes from the registered RAM port and trails the address.
					addr_q <= addr_q + 1'b1;
					if (addr_q != '0) begin
						acc_q <= alu_rsp.acc;
					end
					if (addr_q == LAST_IDX) begin
						state_q <= ST_SUM_LAST;
					end
				end
				ST_SUM_LAST: begin
					acc_q   <= alu_rsp.acc;
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!out_vld_q || result.ready) begin
						out_vld_q    <= 1'b1;
						out_status_q <= status_q;
						out_start_q  <= BIDX_W'(start_q);
						out_holes_q  <= (32'(holes_q) > 32'(HOLES_MAX)) ?
							HOLES_W'(HOLES_MAX) : HOLES_W'(holes_q);
						out_used_q   <= acc_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// A scan never counts more holes than there are blocks.
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(holes_q) <= 32'(NUM_BLOCKS))
		else $error("hole count exceeds the number of blocks");

	// The usage sum reads a memory that no longer changes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM || state_q == ST_SUM_LAST) |-> !ram_we)
		else $error("RAM written during the usage sum");

	// The fill pointer never passes below the start of the run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL_EX) |-> (k_q >= j_q))
		else $error("fill pointer below run start");

	// A run or a fill only works on a request that is still unmet.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN_EX || state_q == ST_FILL_EX) |-> (need_q != '0))
		else $error("run or fill with nothing left to place");

	// A result appears only at the end of an item.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> ($past(state_q) == ST_FINISH))
		else $error("result raised outside the finish step");
`endif
endmodule

`default_nettype wire

>>> src/first_next_fit_block_allocator_unit.sv
// Steps: a release or load writes the addressed block, then sums the usage; an unused kind only
// sums it. An allocate scans blocks, may walk a backward run and fill it, then sums the usage;
// every read of the free-amount RAM needs an address step and a registered-data step, and the
// final usage sum streams one entry per cycle. One item at a time; the next is accepted once the
// result is registered. Reset: a clearing pass zeroes the RAM; items wait, configuration is taken.
// Top level: registers, RAM, ALU, sequencer.
`default_nettype none

module first_next_fit_block_allocator_unit #(
	parameter int NUM_BLOCKS = fnfa_pkg::NUM_BLOCKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fnfa_in_if.sink    item,
	fnfa_out_if.source result,
	fnfa_cfg_if.sink   cfg
);
	import fnfa_pkg::*;

	localparam int IDX_W = $clog2(NUM_BLOCKS);

	free_t            cap_q;
	logic             policy_q;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	free_t            ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	free_t            ram_rdata;
	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;

	assign cfg.ready = 1'b1;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			policy_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_BLOCK_CAPACITY: cap_q <= FREE_W'(cfg.data);
				REG_FIT_POLICY:     policy_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	fnfa_ram #(
		.WIDTH (FREE_W),
		.DEPTH (NUM_BLOCKS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fnfa_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	fnfa_seq #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap       (cap_q),
		.policy    (policy_q),
		.item      (item),
		.result    (result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.alu_req   (alu_req),
		.alu_rsp   (alu_rsp)
	);
endmodule

`default_nettype wire
